@@ sv/rgv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgv_pkg: shared types, constants and table builders
// Word formats, register indexes, controller states and the elaboration-time
// functions that fill the direction/distance and sine tables.
// ----------------------------------------------------------------------------
package rgv_pkg;

   // channel words
   typedef struct packed {
      logic       func;
      logic [3:0] row;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] vert_x;
      logic signed [15:0] vert_y;
      logic [15:0]        vert_z;
      logic [31:0]        vert_colour;
      logic [12:0]        tex_u;
      logic [12:0]        tex_v;
      logic               end_of_strip;
   } rsp_word_type;

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH,
      CSR_GRID_HEIGHT,
      CSR_CENTRE_X,
      CSR_CENTRE_Y,
      CSR_DEPTH_VALUE,
      CSR_MAGNITUDE,
      CSR_TINT
   } csr_index_type;

   localparam logic [15:0] MAGNITUDE_RESET = 16'd4096;
   localparam logic [31:0] TINT_RESET      = 32'hFFFF_FFFF;

   // phase step per tick: 1/(4*pi^2) turn in 1/65536 turn
   localparam logic [15:0] PHASE_STEP = 16'd1660;

   // grid index width, covers the widest supported grid
   localparam int GRID_IDX_W = 6;

   // shade arithmetic: s = 100*2^26 + 3*mag*(t-1), channel = round(c*s/(100*2^26))
   localparam logic signed [35:0] SHADE_BASE  = 36'sd6710886400;
   localparam logic [41:0]        SHADE_ROUND = 42'd3355443200;
   localparam int                 CH_DIV      = 25;
   localparam logic [8:0]         CH_RECIP    = 9'd327;  // floor(2^13/25)
   localparam logic signed [16:0] T_ONE       = 17'sd16384;

   localparam longint unsigned HALF_PI_Q30     = 64'd1686629713;
   localparam longint unsigned TWO_OVER_PI_Q32 = 64'd2734261102;

   // controller states
   typedef enum logic {
      CTRL_IDLE,
      CTRL_EMIT
   } ctrl_state_type;

   // sequencer to datapath command
   typedef struct packed {
      logic                  issue;
      logic                  tick;
      logic [GRID_IDX_W-1:0] col;
      logic [GRID_IDX_W-1:0] grow;
      logic                  eos;
   } cmd_type;

   // one grid point: unit direction to the centre and phase offset
   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [15:0]        dph;
   } offset_entry_type;

   // integer square root, bit by bit
   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bit_v;
      longint unsigned x;
      res   = 0;
      bit_v = 64'h4000_0000_0000_0000;
      x     = v;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > x) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 0) begin
            if (x >= res + bit_v) begin
               x   = x - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // sin(pi/2 * num/Den) in Q14 by a Taylor series
   function automatic longint unsigned quarter_sine(input longint unsigned num,
                                                    input longint unsigned Den);
      longint unsigned q;
      longint unsigned a;
      longint unsigned term;
      longint          sum;
      longint unsigned r;
      longint unsigned Fact;
      q    = (num << 30) / Den;
      a    = (q * HALF_PI_Q30) >> 30;
      term = a;
      sum  = longint'(a);
      for (int n = 1; n <= 8; n++) begin
         term = (term * a) >> 30;
         term = (term * a) >> 30;
         Fact = longint'((2 * n) * (2 * n + 1));
         term = term / Fact;
         if (n % 2 == 1) sum = sum - longint'(term);
         else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 32768) >> 16;
      if (r > 16384) r = 16384;
      return r;
   endfunction

   // one sine sample over a full turn, Q2.14
   function automatic logic signed [15:0] sine_sample(input longint unsigned k,
                                                      input longint unsigned Entries);
      longint unsigned four;
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned v;
      four = 4 * k;
      quad = four / Entries;
      rem  = four % Entries;
      if (quad[0]) v = quarter_sine(Entries - rem, Entries);
      else         v = quarter_sine(rem, Entries);
      if (quad[1]) return -16'(v);
      return 16'(v);
   endfunction

   // direction and phase offset of grid point (x, y); centre point is all zero
   function automatic offset_entry_type offset_entry(input longint x, input longint y,
                                                     input longint Steps);
      offset_entry_type e;
      longint          a;
      longint          b;
      longint unsigned d2;
      longint unsigned S;
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned vx;
      longint unsigned vy;
      longint unsigned ph;
      e  = '0;
      a  = Steps - 2 * x;
      b  = Steps - 2 * y;
      d2 = longint'(a * a + b * b);
      if (d2 != 0) begin
         S  = isqrt(d2 << 28);
         ma = (a < 0) ? longint'(-a) : longint'(a);
         mb = (b < 0) ? longint'(-b) : longint'(b);
         vx = ((ma << 28) + S / 2) / S;
         vy = ((mb << 28) + S / 2) / S;
         ph = (S * TWO_OVER_PI_Q32 + 64'h8000_0000) >> 32;
         e.dir_x = (a < 0) ? -16'(vx) : 16'(vx);
         e.dir_y = (b < 0) ? -16'(vy) : 16'(vy);
         e.dph   = 16'(ph);
      end
      return e;
   endfunction

   // texture coordinate i/Steps in Q1.12, rounded half up
   function automatic logic [12:0] tex_coord(input longint i, input longint Steps);
      return 13'((i * 4096 + Steps / 2) / Steps);
   endfunction

endpackage

@@ sv/rgv_stream_if.sv @@
// ----------------------------------------------------------------------------
// rgv_stream_if: valid/ready channel
// Carries one word per handshake; the word type is set per instance.
// ----------------------------------------------------------------------------
interface rgv_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/rgv_ctrl.sv @@
// ----------------------------------------------------------------------------
// rgv_ctrl: item sequencer
// Accepts request words, issues phase ticks and walks one strip row,
// lower then upper point per column, one vertex per advancing cycle.
// ----------------------------------------------------------------------------
module rgv_ctrl #(
   parameter int GRID_STEPS = 12
) (
   input  logic              clock,
   input  logic              reset,
   rgv_stream_if.sink        req_if,
   input  logic              adv,
   output rgv_pkg::cmd_type  cmd
);
   import rgv_pkg::*;

   localparam int CW = GRID_IDX_W;

   ctrl_state_type  state_ff, state_in;
   logic [CW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic            upper_ff, upper_in;
   logic            last_col;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
         upper_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         upper_ff <= upper_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   assign last_col = (col_ff == CW'(GRID_STEPS));

   // next state and command
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      upper_in     = upper_ff;
      cmd          = '0;
      req_if.ready = (state_ff == CTRL_IDLE);
      case (state_ff)
         CTRL_IDLE: begin
            if (req_if.valid) begin
               if (!req_if.payload.func) begin
                  cmd.tick = 1'b1;
               end else if (CW'(req_if.payload.row) < CW'(GRID_STEPS)) begin
                  row_in   = CW'(req_if.payload.row);
                  col_in   = '0;
                  upper_in = 1'b0;
                  state_in = CTRL_EMIT;
               end
            end
         end
         CTRL_EMIT: begin
            cmd.col  = col_ff;
            cmd.grow = upper_ff ? row_ff : row_ff + CW'(1);
            cmd.eos  = upper_ff && last_col;
            if (adv) begin
               cmd.issue = 1'b1;
               upper_in  = !upper_ff;
               if (upper_ff) begin
                  if (last_col) state_in = CTRL_IDLE;
                  else          col_in   = col_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   a_issue_in_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> state_ff == CTRL_EMIT)
      else $error("vertex issued outside a row");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_EMIT |-> col_ff <= CW'(GRID_STEPS))
      else $error("column past the grid");

   a_eos_ends_row: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && cmd.eos |=> state_ff == CTRL_IDLE)
      else $error("row did not end after last vertex");

endmodule

@@ sv/rgv_datapath.sv @@
// ----------------------------------------------------------------------------
// rgv_datapath: vertex pipeline
// Registers, wave phase, table lookups, displacement, grid offsets and tint
// shading in seven stages; the last stage is the result register.
// ----------------------------------------------------------------------------
module rgv_datapath #(
   parameter int GRID_STEPS   = 12,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rgv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rgv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  rgv_pkg::cmd_type                    cmd,
   output logic                                adv,
   rgv_stream_if.source                        rsp_if
);
   import rgv_pkg::*;

   localparam int CW        = GRID_IDX_W;
   localparam int GP        = GRID_STEPS + 1;
   localparam int ROM_DEPTH = GP * GP;
   localparam int AW        = $clog2(ROM_DEPTH);
   localparam int TW        = $clog2(GP);
   localparam int SW        = $clog2(SINE_ENTRIES);
   localparam int DIV       = 2 * GRID_STEPS;
   // grid numerator (2i+G)*size+G and its reciprocal divide by 2G
   localparam int NW        = $clog2(3 * GRID_STEPS * 65535 + GRID_STEPS + 1);
   localparam logic [NW-1:0] RECIP = NW'((64'd1 << NW) / DIV);
   localparam int OW        = NW + 1;
   localparam int SUMW      = OW + 2;

   typedef struct packed {
      logic [CW-1:0] col;
      logic [CW-1:0] grow;
      logic          eos;
   } tag_type;

   // configuration
   logic [15:0]        cfg_width_ff, cfg_height_ff, cfg_depth_ff, cfg_mag_ff;
   logic signed [15:0] cfg_cx_ff, cfg_cy_ff;
   logic [31:0]        cfg_tint_ff;
   logic [15:0]        phase_ff;

   // constant tables
   offset_entry_type   offset_rom [ROM_DEPTH];
   logic signed [15:0] sine_rom [SINE_ENTRIES];
   logic [12:0]        tex_rom [GP];

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_offset
      assign offset_rom[g] = offset_entry(g % GP, g / GP, GRID_STEPS);
   end
   for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
      assign sine_rom[g] = sine_sample(g, SINE_ENTRIES);
   end
   for (genvar g = 0; g < GP; g++) begin : g_tex
      assign tex_rom[g] = tex_coord(g, GRID_STEPS);
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= '0;
         cfg_height_ff <= '0;
         cfg_cx_ff     <= '0;
         cfg_cy_ff     <= '0;
         cfg_depth_ff  <= '0;
         cfg_mag_ff    <= MAGNITUDE_RESET;
         cfg_tint_ff   <= TINT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  cfg_width_ff  <= csr_wdata[15:0];
            CSR_GRID_HEIGHT: cfg_height_ff <= csr_wdata[15:0];
            CSR_CENTRE_X:    cfg_cx_ff     <= signed'(csr_wdata[15:0]);
            CSR_CENTRE_Y:    cfg_cy_ff     <= signed'(csr_wdata[15:0]);
            CSR_DEPTH_VALUE: cfg_depth_ff  <= csr_wdata[15:0];
            CSR_MAGNITUDE:   cfg_mag_ff    <= csr_wdata[15:0];
            CSR_TINT:        cfg_tint_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // wave phase, moved back one step per tick
   always_ff @(posedge clock) begin
      if (reset)         phase_ff <= '0;
      else if (cmd.tick) phase_ff <= phase_ff - PHASE_STEP;
   end

   // pipeline valid bits
   logic       s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic       out_vld_ff;
   tag_type    s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff, s5_tag_ff, s6_tag_ff;
   rsp_word_type out_word_ff, out_word_in;

   assign adv = !out_vld_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= cmd.issue;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         out_vld_ff <= s6_vld_ff;
      end
   end

   // stage 1: offset table read, grid numerators
   logic [AW-1:0]    rom_addr;
   offset_entry_type s1_entry_ff;
   logic [15:0]      s1_phase_ff;
   logic [NW-1:0]    s1_nx_ff, s1_ny_ff, s1_nx_in, s1_ny_in;

   assign rom_addr = AW'(32'(cmd.grow) * GP + 32'(cmd.col));
   assign s1_nx_in = NW'((NW'(2) * NW'(cmd.col) + NW'(GRID_STEPS)) * NW'(cfg_width_ff))
                     + NW'(GRID_STEPS);
   assign s1_ny_in = NW'((NW'(2) * NW'(cmd.grow) + NW'(GRID_STEPS)) * NW'(cfg_height_ff))
                     + NW'(GRID_STEPS);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_entry_ff <= offset_rom[rom_addr];
         s1_phase_ff <= phase_ff;
         s1_nx_ff    <= s1_nx_in;
         s1_ny_ff    <= s1_ny_in;
         s1_tag_ff   <= '{col: cmd.col, grow: cmd.grow, eos: cmd.eos};
      end
   end

   // stage 2: sine read, quotient estimates
   logic [15:0]        sine_arg;
   logic [SW-1:0]      sine_idx;
   logic [2*NW-1:0]    qx_prod, qy_prod;
   logic signed [15:0] s2_t_ff, s2_dx_ff, s2_dy_ff;
   logic [NW-1:0]      s2_nx_ff, s2_ny_ff, s2_qx_ff, s2_qy_ff;

   assign sine_arg = s1_entry_ff.dph + s1_phase_ff;
   assign sine_idx = SW'((32'(sine_arg) * SINE_ENTRIES) >> 16);
   assign qx_prod  = (2*NW)'(s1_nx_ff) * (2*NW)'(RECIP);
   assign qy_prod  = (2*NW)'(s1_ny_ff) * (2*NW)'(RECIP);

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_t_ff   <= sine_rom[sine_idx];
         s2_dx_ff  <= s1_entry_ff.dir_x;
         s2_dy_ff  <= s1_entry_ff.dir_y;
         s2_nx_ff  <= s1_nx_ff;
         s2_ny_ff  <= s1_ny_ff;
         s2_qx_ff  <= qx_prod[2*NW-1:NW];
         s2_qy_ff  <= qy_prod[2*NW-1:NW];
         s2_tag_ff <= s1_tag_ff;
      end
   end

   // stage 3: quotient correction, direction*t, magnitude*(t-1)
   logic [NW-1:0]      rx, ry, qx_c, qy_c;
   logic signed [16:0] t_minus;
   logic signed [31:0] s3_px_ff, s3_py_ff;
   logic signed [33:0] s3_md_ff;
   logic signed [OW-1:0] s3_offx_ff, s3_offy_ff;

   assign rx      = s2_nx_ff - NW'(s2_qx_ff * NW'(DIV));
   assign ry      = s2_ny_ff - NW'(s2_qy_ff * NW'(DIV));
   assign qx_c    = (rx >= NW'(DIV)) ? s2_qx_ff + NW'(1) : s2_qx_ff;
   assign qy_c    = (ry >= NW'(DIV)) ? s2_qy_ff + NW'(1) : s2_qy_ff;
   assign t_minus = 17'(s2_t_ff) - T_ONE;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_px_ff   <= 32'(s2_dx_ff) * 32'(s2_t_ff);
         s3_py_ff   <= 32'(s2_dy_ff) * 32'(s2_t_ff);
         s3_md_ff   <= 34'($signed({1'b0, cfg_mag_ff})) * 34'(t_minus);
         s3_offx_ff <= $signed({1'b0, qx_c}) - $signed(OW'(cfg_width_ff));
         s3_offy_ff <= $signed({1'b0, qy_c}) - $signed(OW'(cfg_height_ff));
         s3_tag_ff  <= s2_tag_ff;
      end
   end

   // stage 4: displacement products, shade factor
   logic signed [48:0]   s4_pmx_ff, s4_pmy_ff;
   logic signed [35:0]   s4_s_ff;
   logic signed [OW-1:0] s4_offx_ff, s4_offy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_pmx_ff  <= 49'(s3_px_ff) * 49'($signed({1'b0, cfg_mag_ff}));
         s4_pmy_ff  <= 49'(s3_py_ff) * 49'($signed({1'b0, cfg_mag_ff}));
         s4_s_ff    <= SHADE_BASE + 36'(s3_md_ff) + 36'(s3_md_ff <<< 1);
         s4_offx_ff <= s3_offx_ff;
         s4_offy_ff <= s3_offy_ff;
         s4_tag_ff  <= s3_tag_ff;
      end
   end

   // rounds v / 2^36 half away from zero
   function automatic logic signed [12:0] round36(input logic signed [48:0] v);
      logic [48:0] mag_v;
      logic [48:0] sh;
      mag_v = v[48] ? 49'(-v) : 49'(v);
      sh    = (mag_v + (49'd1 << 35)) >> 36;
      return v[48] ? -13'(sh) : 13'(sh);
   endfunction

   // saturates to the 16-bit coordinate range
   function automatic logic signed [15:0] sat16(input logic signed [SUMW-1:0] v);
      if (v > SUMW'(32767))  return 16'sh7FFF;
      if (v < -SUMW'(32768)) return 16'sh8000;
      return 16'(v);
   endfunction

   // stage 5: coordinates, channel products
   logic signed [SUMW-1:0] sum_x, sum_y;
   logic                   s_pos;
   logic [41:0]            ch_prod [3];
   logic signed [15:0]     s5_x_ff, s5_y_ff;
   logic [12:0]            s5_xq_ff [3];

   assign sum_x = SUMW'(cfg_cx_ff) + SUMW'(s4_offx_ff) + SUMW'(round36(s4_pmx_ff));
   assign sum_y = SUMW'(cfg_cy_ff) + SUMW'(s4_offy_ff) + SUMW'(round36(s4_pmy_ff));
   assign s_pos = (s4_s_ff > 36'sd0);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ch_prod[c] = 42'(cfg_tint_ff[8*c +: 8]) * 42'(s4_s_ff[32:0]) + SHADE_ROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_x_ff   <= sat16(sum_x);
         s5_y_ff   <= sat16(sum_y);
         for (int c = 0; c < 3; c++) begin
            s5_xq_ff[c] <= s_pos ? ch_prod[c][40:28] : 13'd0;
         end
         s5_tag_ff <= s4_tag_ff;
      end
   end

   // stage 6: channel divide-by-25 estimate
   logic [21:0]        ch_est [3];
   logic [12:0]        s6_xq_ff [3];
   logic [8:0]         s6_q_ff [3];
   logic signed [15:0] s6_x_ff, s6_y_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ch_est[c] = 22'(s5_xq_ff[c]) * 22'(CH_RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            s6_xq_ff[c] <= s5_xq_ff[c];
            s6_q_ff[c]  <= ch_est[c][21:13];
         end
         s6_x_ff   <= s5_x_ff;
         s6_y_ff   <= s5_y_ff;
         s6_tag_ff <= s5_tag_ff;
      end
   end

   // stage 7: correction, clamp, result register
   logic [12:0] ch_rem [3];
   logic [9:0]  ch_q [3];
   logic [7:0]  ch_out [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ch_rem[c] = s6_xq_ff[c] - 13'(s6_q_ff[c] * 13'(CH_DIV));
         ch_q[c]   = (ch_rem[c] >= 13'(CH_DIV)) ? 10'(s6_q_ff[c]) + 10'd1
                                                : 10'(s6_q_ff[c]);
         ch_out[c] = (ch_q[c] > 10'd255) ? 8'hFF : ch_q[c][7:0];
      end
      out_word_in.vert_x       = s6_x_ff;
      out_word_in.vert_y       = s6_y_ff;
      out_word_in.vert_z       = cfg_depth_ff;
      out_word_in.vert_colour  = {cfg_tint_ff[31:24], ch_out[2], ch_out[1], ch_out[0]};
      out_word_in.tex_u        = tex_rom[s6_tag_ff.col[TW-1:0]];
      out_word_in.tex_v        = tex_rom[s6_tag_ff.grow[TW-1:0]];
      out_word_in.end_of_strip = s6_tag_ff.eos;
   end

   always_ff @(posedge clock) begin
      if (adv) out_word_ff <= out_word_in;
   end

   assign rsp_if.valid   = out_vld_ff;
   assign rsp_if.payload = out_word_ff;

   a_tick_not_in_row: assert property (@(posedge clock) disable iff (reset)
      cmd.tick |-> !cmd.issue)
      else $error("phase tick during a row");

   a_issue_only_on_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> adv)
      else $error("vertex issued into a stalled pipeline");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.payload))
      else $error("result word changed while waiting");

endmodule

@@ sv/ripple_grid_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// ripple_grid_vertex_generator: rippling grid triangle-strip source
// Top level: sequencer and seven-stage vertex datapath.
// ----------------------------------------------------------------------------
// A tick word moves the wave phase back one step; a row word produces
// 2*(GRID_STEPS+1) vertex words (26 by default), one per cycle unless the
// datapath stalls, lower then upper point per column, the last one flagged
// end_of_strip. The sequencer takes the next request word in the cycle after
// it issues a row's last vertex; the seven-stage datapath stalls as a whole
// while the result register waits. Row words with row >= GRID_STEPS produce
// nothing. The tables are constants, so there is no start-up pass after
// reset. Registers are to be written only while the block is idle.
// ----------------------------------------------------------------------------
module ripple_grid_vertex_generator #(
   parameter int GRID_STEPS   = 12,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   rgv_stream_if.sink                      req_if,
   rgv_stream_if.source                    rsp_if,
   input  logic                            csr_we,
   input  logic [rgv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rgv_pkg::*;

   cmd_type cmd;
   logic    adv;

   rgv_ctrl #(
      .GRID_STEPS (GRID_STEPS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .adv    (adv),
      .cmd    (cmd)
   );

   rgv_datapath #(
      .GRID_STEPS   (GRID_STEPS),
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .adv       (adv),
      .rsp_if    (rsp_if)
   );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: ripple grid vertex generator check
// Drives tick and row words with random idling on both channels, moves the
// register settings between phases while the block is idle, and compares
// every vertex word with an independent model of the ripple grid.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rgv_pkg::*;

   localparam int  STEPS     = 12;
   localparam int  PTS       = STEPS + 1;
   localparam int  LIMIT     = 600000;
   localparam longint SHADE_DIV = 64'sd6710886400;  // 100 * 2^26

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic calm = 1'b0;
   int   errors = 0;
   int   cycles = 0;

   rgv_stream_if #(.payload_type(req_word_type)) req_ch ();
   rgv_stream_if #(.payload_type(rsp_word_type)) rsp_ch ();

   ripple_grid_vertex_generator DUT (
      .clock(clock), .reset(reset),
      .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // model state
   localparam int SINE_ENTRIES_TB = 1024;
   logic signed [15:0] sine_q14 [SINE_ENTRIES_TB];
   logic signed [15:0] dir_x_tab [PTS][PTS];
   logic signed [15:0] dir_y_tab [PTS][PTS];
   logic [15:0]        dph_tab   [PTS][PTS];
   logic [15:0] wave_turns;
   logic [15:0] m_width, m_height, m_depth, m_mag;
   logic signed [15:0] m_cx, m_cy;
   logic [31:0] m_tint;
   rsp_word_type pending_vertices [$];

   // ------------------------------------------------------------------
   // table builders
   // ------------------------------------------------------------------
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned acc, probe;
      acc = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= acc + probe) begin
            v -= acc + probe;
            acc = (acc >> 1) + probe;
         end else begin
            acc >>= 1;
         end
         probe >>= 2;
      end
      return acc;
   endfunction

   // sin(pi/2 * num/den), Q14, series in Q30
   function automatic longint quarter_wave(longint unsigned num, longint unsigned den);
      longint unsigned q, a, term, r;
      longint sum;
      q = (num << 30) / den;
      a = (q * 64'd1686629713) >> 30;
      term = a;
      sum = longint'(a);
      for (int n = 1; n <= 8; n++) begin
         term = (term * a) >> 30;
         term = (term * a) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 32768) >> 16;
      if (r > 16384) r = 16384;
      return longint'(r);
   endfunction

   task automatic build_model_tables();
      longint unsigned quad, rem, s, ma, mb;
      longint v, a, b;
      for (int k = 0; k < SINE_ENTRIES_TB; k++) begin
         quad = (4 * k) / SINE_ENTRIES_TB;
         rem  = (4 * k) % SINE_ENTRIES_TB;
         v = quad[0] ? quarter_wave(SINE_ENTRIES_TB - rem, SINE_ENTRIES_TB)
                     : quarter_wave(rem, SINE_ENTRIES_TB);
         sine_q14[k] = quad[1] ? 16'(-v) : 16'(v);
      end
      for (int y = 0; y < PTS; y++) begin
         for (int x = 0; x < PTS; x++) begin
            a = STEPS - 2 * x;
            b = STEPS - 2 * y;
            dir_x_tab[y][x] = '0;
            dir_y_tab[y][x] = '0;
            dph_tab[y][x]   = '0;
            // centre point keeps zero direction and phase
            if (a * a + b * b != 0) begin
               s  = root_floor(longint'(a * a + b * b) << 28);
               ma = (a < 0) ? -a : a;
               mb = (b < 0) ? -b : b;
               v = longint'(((ma << 28) + s / 2) / s);
               dir_x_tab[y][x] = (a < 0) ? 16'(-v) : 16'(v);
               v = longint'(((mb << 28) + s / 2) / s);
               dir_y_tab[y][x] = (b < 0) ? 16'(-v) : 16'(v);
               dph_tab[y][x] = 16'((s * 64'd2734261102 + 64'h8000_0000) >> 32);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // vertex model
   // ------------------------------------------------------------------
   function automatic longint round_away(longint v);
      if (v >= 0) return (v + (64'sd1 <<< 35)) >>> 36;
      return -((-v + (64'sd1 <<< 35)) >>> 36);
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic longint point_offset(int i, longint size);
      return ((2 * i - STEPS) * size + STEPS + 2 * STEPS * size) / (2 * STEPS) - size;
   endfunction

   function automatic rsp_word_type ripple_vertex(int col, int grow, bit last);
      rsp_word_type w;
      logic [15:0] arg;
      longint t, s, c, ch;
      arg = dph_tab[grow][col] + wave_turns;
      t = sine_q14[arg >> 6];
      w.vert_x = clamp16(longint'(m_cx) + point_offset(col, m_width)
                 + round_away(longint'(dir_x_tab[grow][col]) * t * longint'(m_mag)));
      w.vert_y = clamp16(longint'(m_cy) + point_offset(grow, m_height)
                 + round_away(longint'(dir_y_tab[grow][col]) * t * longint'(m_mag)));
      w.vert_z = m_depth;
      // shade RGB, a negative factor clamps to black, alpha passes
      s = SHADE_DIV + 3 * longint'(m_mag) * (t - 16384);
      w.vert_colour = {m_tint[31:24], 24'h0};
      for (int sh = 0; sh < 24; sh += 8) begin
         c = (m_tint >> sh) & 32'hFF;
         ch = 0;
         if (s > 0) begin
            ch = (c * s + SHADE_DIV / 2) / SHADE_DIV;
            if (ch > 255) ch = 255;
         end
         w.vert_colour |= 32'(ch) << sh;
      end
      w.tex_u = 13'((col * 4096 + STEPS / 2) / STEPS);
      w.tex_v = 13'((grow * 4096 + STEPS / 2) / STEPS);
      w.end_of_strip = last;
      return w;
   endfunction

   task automatic predict_strip(req_word_type w);
      if (!w.func) begin
         wave_turns = wave_turns - PHASE_STEP;
      end else if (w.row < STEPS) begin
         for (int col = 0; col < PTS; col++) begin
            pending_vertices.push_back(ripple_vertex(col, w.row + 1, 1'b0));
            pending_vertices.push_back(ripple_vertex(col, w.row, col == STEPS));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // clock, cycle limit
   // ------------------------------------------------------------------
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stall, compare
   always @(posedge clock) begin
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_vertices.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected vertex word %p", rsp_ch.payload);
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_ch.payload.vert_x !== want.vert_x
                || rsp_ch.payload.vert_y !== want.vert_y
                || rsp_ch.payload.vert_z !== want.vert_z
                || rsp_ch.payload.vert_colour !== want.vert_colour
                || rsp_ch.payload.tex_u !== want.tex_u
                || rsp_ch.payload.tex_v !== want.tex_v
                || rsp_ch.payload.end_of_strip !== want.end_of_strip) begin
               errors++;
               if (errors <= 10)
                  $display("vertex mismatch\n  exp %p\n  got %p", want, rsp_ch.payload);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic push_word(req_word_type w);
      int gap;
      if (!calm && $urandom_range(99) < 35) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      do @(posedge clock); while (!req_ch.ready);
      predict_strip(w);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] vals [7]);
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      m_width  = vals[CSR_GRID_WIDTH][15:0];
      m_height = vals[CSR_GRID_HEIGHT][15:0];
      m_cx     = vals[CSR_CENTRE_X][15:0];
      m_cy     = vals[CSR_CENTRE_Y][15:0];
      m_depth  = vals[CSR_DEPTH_VALUE][15:0];
      m_mag    = vals[CSR_MAGNITUDE][15:0];
      m_tint   = vals[CSR_TINT];
   endtask

   // directed words: every row, rows past the grid, ticks with stray row bits
   req_word_type directed_words [20] = '{
      '{1'b1, 4'd0},  '{1'b1, 4'd11}, '{1'b1, 4'd5},  '{1'b0, 4'd0},
      '{1'b1, 4'd6},  '{1'b1, 4'd12}, '{1'b1, 4'd15}, '{1'b0, 4'd15},
      '{1'b1, 4'd1},  '{1'b1, 4'd2},  '{1'b1, 4'd3},  '{1'b1, 4'd4},
      '{1'b0, 4'd7},  '{1'b1, 4'd7},  '{1'b1, 4'd8},  '{1'b1, 4'd9},
      '{1'b1, 4'd10}, '{1'b1, 4'd13}, '{1'b0, 4'd10}, '{1'b1, 4'd11}
   };

   initial begin
      logic [31:0] regs [7];
      req_word_type w;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      build_model_tables();
      wave_turns = '0;
      m_width = '0; m_height = '0; m_cx = '0; m_cy = '0; m_depth = '0;
      m_mag = MAGNITUDE_RESET;
      m_tint = TINT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: directed table
      foreach (directed_words[i]) push_word(directed_words[i]);
      drain();

      for (int phase = 1; phase <= 4; phase++) begin
         case (phase)
            1: regs = '{32'd3072, 32'd2048, 32'd1600, 32'd1200, 32'h1234, 32'd4096,
                        32'h80C0_4020};
            // largest values: saturation and strong ripple
            2: regs = '{32'hFFFF, 32'hFFFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFFFF,
                        32'hFFFF_FFFF};
            // smallest values
            3: regs = '{32'd0, 32'd0, 32'h8000, 32'h8000, 32'd0, 32'd0, 32'd0};
            default: begin
               foreach (regs[i]) regs[i] = $urandom;
               regs[CSR_MAGNITUDE] = $urandom_range(0, 20000);
            end
         endcase
         write_regs(regs);
         for (int n = 0; n < 105; n++) begin
            calm = (phase == 4 && n < 60);
            w.func = ($urandom_range(99) >= 25);
            w.row  = (w.func && $urandom_range(99) < 90) ? 4'($urandom_range(0, 11))
                                                       : 4'($urandom_range(0, 15));
            push_word(w);
         end
         calm = 1'b0;
         drain();
      end

      if (errors == 0 && pending_vertices.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
